// File: sv/assert_macros.svh
// Assertion macros used by the top level of the frame rate mode estimator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define ASSERT_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) else $error(msg);

`endif

// File: sv/fre_pkg.sv
// Shared types and constants of the frame rate mode estimator.
`default_nettype none

package fre_pkg;

  localparam int TS_W      = 64;
  localparam int GAP_W     = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int MIN_W     = 30;
  localparam int EST_W     = 8;
  localparam int CNT_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = 2'd2;

  localparam logic [EST_W-1:0] EMPTY_RATE       = 8'd30;
  localparam logic [EST_W-1:0] RESET_RATE       = 8'd30;
  localparam logic [MIN_W-1:0] RESET_MIN_NS     = 30'd1000000;
  localparam logic [GAP_W-1:0] RESET_MAX_NS     = 32'd1000000000;
  localparam logic [CNT_W-1:0] COUNT_MAX        = 32'hFFFF_FFFF;

  typedef struct packed {
    logic capture;
    logic check;
    logic div_start;
    logic div_step;
    logic round;
    logic rd;
    logic update;
    logic finish;
    logic load_out;
  } fre_cmd_t;

  typedef struct packed {
    logic in_bounds;
    logic div_last;
    logic hit;
  } fre_status_t;

endpackage

`default_nettype wire

// File: sv/fre_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 240
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/fre_ctrl.sv
// Controller state machine of the frame rate mode estimator.
`default_nettype none

module fre_ctrl import fre_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  output      logic        out_valid,
  input  wire logic        out_ready,
  input  wire fre_status_t status,
  output      fre_cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b0_0000_0001,
    S_CHECK  = 9'b0_0000_0010,
    S_BOUND  = 9'b0_0000_0100,
    S_DIV    = 9'b0_0000_1000,
    S_ROUND  = 9'b0_0001_0000,
    S_READ   = 9'b0_0010_0000,
    S_UPDATE = 9'b0_0100_0000,
    S_FINISH = 9'b0_1000_0000,
    S_DONE   = 9'b1_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd           = '0;
    cmd.capture   = (state == S_IDLE) && in_valid;
    cmd.check     = (state == S_CHECK);
    cmd.div_start = (state == S_BOUND);
    cmd.div_step  = (state == S_DIV);
    cmd.round     = (state == S_ROUND);
    cmd.rd        = (state == S_READ);
    cmd.update    = (state == S_UPDATE);
    cmd.finish    = (state == S_FINISH);
    cmd.load_out  = (state == S_DONE) && out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK:  state_next = S_BOUND;
      S_BOUND: begin
        state_next = status.in_bounds ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (status.div_last) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        state_next = status.hit ? S_READ : S_FINISH;
      end
      S_READ:   state_next = S_UPDATE;
      S_UPDATE: state_next = S_FINISH;
      S_FINISH: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/fre_datapath.sv
// Datapath: gap check, radix-2 divider, histogram bins and mode tracking.
`default_nettype none

module fre_datapath import fre_pkg::*; #(
  parameter int MAX_RATE         = 240,
  parameter int TICKS_PER_SECOND = 1000000000
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [TS_W-1:0]      timestamp,
  input  wire logic                 timestamp_valid,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire fre_cmd_t             cmd,
  output      fre_status_t          status,
  output      logic [EST_W-1:0]     rate_estimate,
  output      logic                 interval_counted
);

  localparam int TW = $clog2(TICKS_PER_SECOND + 1);
  localparam int BW = $clog2(MAX_RATE + 1);
  localparam int AW = $clog2(MAX_RATE);
  localparam int CW = $clog2(TW);
  localparam logic [TW-1:0] DIVIDEND = TW'(TICKS_PER_SECOND);

  logic [MIN_W-1:0]    min_ns;
  logic [GAP_W-1:0]    max_ns;
  logic [TS_W-1:0]     ts_in;
  logic                tv_in;
  logic [TS_W-1:0]     prev_ts;
  logic                prev_seen;
  logic [TS_W-1:0]     gap;
  logic                gap_ok;
  logic [GAP_W-1:0]    rem;
  logic [TW-1:0]       dq;
  logic [CW-1:0]       div_cnt;
  logic [BW-1:0]       bin;
  logic [MAX_RATE-1:0] bin_valid;
  logic                vq;
  logic [BW-1:0]       mode_bin;
  logic [CNT_W-1:0]    mode_cnt;
  logic [EST_W-1:0]    cur_est;
  logic                counted;

  logic [TS_W:0]       sub;
  logic [GAP_W-1:0]    g;
  logic [GAP_W:0]      shifted;
  logic [GAP_W:0]      diff;
  logic                ge;
  logic                rnd;
  logic [TW:0]         e_full;
  logic [BW-1:0]       bin_m1;
  logic [AW-1:0]       addr;
  logic [CNT_W-1:0]    rdata;
  logic [CNT_W-1:0]    cnt_cur;
  logic [CNT_W-1:0]    cnt_new;
  logic                take;

  assign sub     = {1'b0, ts_in} - {1'b0, prev_ts};
  assign g       = gap[GAP_W-1:0];
  assign shifted = {rem, dq[TW-1]};
  assign diff    = shifted - {1'b0, g};
  assign ge      = (shifted >= {1'b0, g});
  assign rnd     = (rem >= (g - rem));
  assign e_full  = {1'b0, dq} + (TW+1)'(rnd);
  assign bin_m1  = bin - BW'(1);
  assign addr    = bin_m1[AW-1:0];
  assign cnt_cur = vq ? rdata : '0;
  assign cnt_new = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + CNT_W'(1);
  assign take    = (bin == mode_bin) || (cnt_new > mode_cnt) ||
                   ((cnt_new == mode_cnt) && (bin < mode_bin));

  assign status.in_bounds = gap_ok && (gap[TS_W-1:GAP_W] == '0) &&
                            (g > {2'b00, min_ns}) && (g < max_ns);
  assign status.div_last  = (div_cnt == CW'(TW - 1));
  assign status.hit       = (e_full != '0) && (e_full <= (TW+1)'(MAX_RATE));

  fre_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_RATE)
  ) u_bins (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (addr),
    .wdata (cnt_new),
    .re    (cmd.rd),
    .raddr (addr),
    .rdata (rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      min_ns    <= RESET_MIN_NS;
      max_ns    <= RESET_MAX_NS;
      cur_est   <= RESET_RATE;
      prev_seen <= 1'b0;
      bin_valid <= '0;
      mode_bin  <= BW'(EMPTY_RATE);
      mode_cnt  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INITIAL_RATE: cur_est <= cfg_data[EST_W-1:0];
          CFG_MIN_INTERVAL: min_ns  <= cfg_data[MIN_W-1:0];
          CFG_MAX_INTERVAL: max_ns  <= cfg_data[GAP_W-1:0];
          default:          ;
        endcase
      end
      if (cmd.check && tv_in) begin
        prev_seen <= 1'b1;
      end
      if (cmd.update) begin
        bin_valid[addr] <= 1'b1;
        if (take) begin
          mode_bin <= bin;
          mode_cnt <= cnt_new;
        end
      end
      if (cmd.finish) begin
        cur_est <= EST_W'(mode_bin);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ts_in   <= timestamp;
      tv_in   <= timestamp_valid;
      counted <= 1'b0;
    end
    if (cmd.check) begin
      gap    <= sub[TS_W-1:0];
      gap_ok <= tv_in && prev_seen && !sub[TS_W] && (sub[TS_W-1:0] != '0);
      if (tv_in) begin
        prev_ts <= ts_in;
      end
    end
    if (cmd.div_start) begin
      rem     <= '0;
      dq      <= DIVIDEND;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      rem     <= ge ? diff[GAP_W-1:0] : shifted[GAP_W-1:0];
      dq      <= {dq[TW-2:0], ge};
      div_cnt <= div_cnt + CW'(1);
    end
    if (cmd.round) begin
      bin <= e_full[BW-1:0];
    end
    if (cmd.rd) begin
      vq <= bin_valid[addr];
    end
    if (cmd.update) begin
      counted <= 1'b1;
    end
    if (cmd.load_out) begin
      rate_estimate    <= cur_est;
      interval_counted <= counted;
    end
  end

endmodule

`default_nettype wire

// File: sv/frame_rate_mode_estimator_unit.sv
// Top level of the frame rate mode estimator.
//
// Input channel: in_valid/in_ready carry one timestamp beat (timestamp and
// timestamp_valid). Output channel: out_valid/out_ready carry one result beat
// (rate_estimate, interval_counted) for every input beat, in order.
// One beat is worked on at a time. A beat whose gap is not tested or falls
// outside the interval bounds goes from the check and bound states to its
// result register without division. A beat with an accepted gap runs a
// radix-2 divider of one quotient bit per cycle over the tick count (30 steps
// at 1e9 ticks), then a read and write of the bin RAM, which is skipped when
// the rate value falls in no bin. The next beat can be taken in the cycle
// after the result is registered. The output register holds a result while
// out_ready is low; a new beat is still accepted then, and its result waits
// until the register frees.
// Reset clears the bins at once through per-bin valid bits (no clearing pass),
// restores the bound registers and sets the estimate to 30. Configuration
// writes take effect at the clock edge of cfg_we.
`default_nettype none

module frame_rate_mode_estimator_unit import fre_pkg::*; #(
  parameter int MAX_RATE         = 240,
  parameter int TICKS_PER_SECOND = 1000000000
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [TS_W-1:0]      timestamp,
  input  wire logic                 timestamp_valid,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic [EST_W-1:0]     rate_estimate,
  output      logic                 interval_counted,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  fre_cmd_t    cmd;
  fre_status_t status;

  fre_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  fre_datapath #(
    .MAX_RATE         (MAX_RATE),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .timestamp        (timestamp),
    .timestamp_valid  (timestamp_valid),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .status           (status),
    .rate_estimate    (rate_estimate),
    .interval_counted (interval_counted)
  );

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_ready_not_busy, !(in_ready && (cmd.div_step || cmd.update)), "ready while busy")
  `ASSERT_ALWAYS(a_load_free, !cmd.load_out || !out_valid || out_ready, "result overwritten")
  `ASSERT_NEXT(a_beat_busy, in_valid && in_ready, !in_ready, "second beat taken while busy")
  `ASSERT_NEXT(a_read_update, cmd.rd, cmd.update, "bin read not followed by update")

endmodule

`default_nettype wire
